[rtl/core/yee_curl_field_update_top_assert.svh]
// assertion macros for the curl update pipeline
// used by ycfu_pipe_ctrl; expects clk and rst_n in scope
`ifndef YEE_CURL_FIELD_UPDATE_TOP_ASSERT_SVH
`define YEE_CURL_FIELD_UPDATE_TOP_ASSERT_SVH

// consequence must hold on the next clock
`define YCFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ycfu pipeline check failed");

// consequence must hold on the same clock
`define YCFU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ycfu pipeline check failed");

`endif

[rtl/core/ycfu_pkg.sv]
// shared constants and types for the yee curl field update block
// no dependencies
package ycfu_pkg;

    localparam int FIELD_BITS_DEFAULT = 32;
    localparam int COEF_BITS          = 18;
    localparam int COEF_FRAC          = 16;
    localparam int DIM_BITS           = 2;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int CFG_DATA_BITS      = 18;
    localparam int NUM_STAGES         = 5;
    localparam int ROUND_HALF         = 1 << (COEF_FRAC - 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COEFFICIENT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_DIMENSIONS  = 1'd1;

    localparam logic [COEF_BITS-1:0] COEF_RESET = 18'd65536;
    localparam logic [DIM_BITS-1:0]  DIM_TWO    = 2'd2;
    localparam logic [DIM_BITS-1:0]  DIM_THREE  = 2'd3;
    localparam logic [DIM_BITS-1:0]  DIM_RESET  = DIM_THREE;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } ycfu_pipe_ctrl_t;

endpackage

[rtl/core/ycfu_if.sv]
// valid/ready stream interfaces for cell items and update results
// depends on ycfu_pkg
interface ycfu_item_if #(parameter int FIELD_BITS = ycfu_pkg::FIELD_BITS_DEFAULT);
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] target_x;
    logic signed [FIELD_BITS-1:0] target_y;
    logic signed [FIELD_BITS-1:0] target_z;
    logic signed [FIELD_BITS-1:0] source_x;
    logic signed [FIELD_BITS-1:0] source_y;
    logic signed [FIELD_BITS-1:0] source_z;
    logic signed [FIELD_BITS-1:0] source_x_near_j;
    logic signed [FIELD_BITS-1:0] source_x_near_k;
    logic signed [FIELD_BITS-1:0] source_y_near_i;
    logic signed [FIELD_BITS-1:0] source_y_near_k;
    logic signed [FIELD_BITS-1:0] source_z_near_i;
    logic signed [FIELD_BITS-1:0] source_z_near_j;

    modport source (
        output valid, target_x, target_y, target_z, source_x, source_y, source_z,
        output source_x_near_j, source_x_near_k, source_y_near_i, source_y_near_k,
        output source_z_near_i, source_z_near_j,
        input  ready
    );
    modport sink (
        input  valid, target_x, target_y, target_z, source_x, source_y, source_z,
        input  source_x_near_j, source_x_near_k, source_y_near_i, source_y_near_k,
        input  source_z_near_i, source_z_near_j,
        output ready
    );
endinterface

interface ycfu_result_if #(parameter int FIELD_BITS = ycfu_pkg::FIELD_BITS_DEFAULT);
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] updated_x;
    logic signed [FIELD_BITS-1:0] updated_y;
    logic signed [FIELD_BITS-1:0] updated_z;
    logic                         saturated;

    modport source (output valid, updated_x, updated_y, updated_z, saturated, input ready);
    modport sink (input valid, updated_x, updated_y, updated_z, saturated, output ready);
endinterface

[rtl/core/ycfu_pipe_ctrl.sv]
// valid bits and stage load enables for the curl update pipeline
// depends on ycfu_pkg and yee_curl_field_update_top_assert.svh
`include "yee_curl_field_update_top_assert.svh"

module ycfu_pipe_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ycfu_pkg::ycfu_pipe_ctrl_t ctrl
);

    localparam int N = ycfu_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] load;
    logic [N-1:0] prev_valid;

    always_comb
    begin
        load[N-1] = !valid_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        prev_valid = {valid_reg[N-2:0], in_valid};
        for (int i = 0; i < N; i++)
        begin
            valid_next[i] = load[i] ? prev_valid[i] : valid_reg[i];
        end
        ctrl.en = load & prev_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[N-1];

    // accepted beat lands in the first stage
    `YCFU_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, valid_reg[0])
    // a stalled result is never dropped
    `YCFU_ASSERT_NEXT(a_stall_keeps, valid_reg[N-1] && !out_ready, valid_reg[N-1])
    // back pressure only when every stage is full and the sink stalls
    `YCFU_ASSERT_SAME(a_full_stall, !in_ready, (&valid_reg) && !out_ready)

endmodule

[rtl/core/ycfu_curl_diff.sv]
// first stage: forms the three curl differences from the neighbor values
// depends on ycfu_pkg
module ycfu_curl_diff #(
    parameter int FIELD_BITS = ycfu_pkg::FIELD_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [ycfu_pkg::DIM_BITS-1:0]         dims,
    input  logic signed [FIELD_BITS-1:0]          target_x,
    input  logic signed [FIELD_BITS-1:0]          target_y,
    input  logic signed [FIELD_BITS-1:0]          target_z,
    input  logic signed [FIELD_BITS-1:0]          source_x,
    input  logic signed [FIELD_BITS-1:0]          source_y,
    input  logic signed [FIELD_BITS-1:0]          source_z,
    input  logic signed [FIELD_BITS-1:0]          source_x_near_j,
    input  logic signed [FIELD_BITS-1:0]          source_x_near_k,
    input  logic signed [FIELD_BITS-1:0]          source_y_near_i,
    input  logic signed [FIELD_BITS-1:0]          source_y_near_k,
    input  logic signed [FIELD_BITS-1:0]          source_z_near_i,
    input  logic signed [FIELD_BITS-1:0]          source_z_near_j,
    output logic signed [FIELD_BITS+1:0]          diff_x,
    output logic signed [FIELD_BITS+1:0]          diff_y,
    output logic signed [FIELD_BITS+1:0]          diff_z,
    output logic signed [FIELD_BITS-1:0]          tgt_x,
    output logic signed [FIELD_BITS-1:0]          tgt_y,
    output logic signed [FIELD_BITS-1:0]          tgt_z,
    output logic                                  hold_x
);

    localparam int DIFF_W = FIELD_BITS + 2;

    logic                     use_j;
    logic                     use_k;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [DIFF_W-1:0] dz_next;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dz_reg;
    logic signed [FIELD_BITS-1:0] tx_reg;
    logic signed [FIELD_BITS-1:0] ty_reg;
    logic signed [FIELD_BITS-1:0] tz_reg;
    logic                     hold_x_reg;

    always_comb
    begin
        use_j = dims >= ycfu_pkg::DIM_TWO;
        use_k = dims == ycfu_pkg::DIM_THREE;
        dx_next = (use_k ? DIFF_W'(source_y_near_k) - DIFF_W'(source_y) : '0)
                + (use_j ? DIFF_W'(source_z) - DIFF_W'(source_z_near_j) : '0);
        dy_next = (use_k ? DIFF_W'(source_x) - DIFF_W'(source_x_near_k) : '0)
                + (DIFF_W'(source_z_near_i) - DIFF_W'(source_z));
        dz_next = (use_j ? DIFF_W'(source_x_near_j) - DIFF_W'(source_x) : '0)
                + (DIFF_W'(source_y) - DIFF_W'(source_y_near_i));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dz_reg     <= dz_next;
            tx_reg     <= target_x;
            ty_reg     <= target_y;
            tz_reg     <= target_z;
            hold_x_reg <= !use_j;
        end
    end

    assign diff_x = dx_reg;
    assign diff_y = dy_reg;
    assign diff_z = dz_reg;
    assign tgt_x  = tx_reg;
    assign tgt_y  = ty_reg;
    assign tgt_z  = tz_reg;
    assign hold_x = hold_x_reg;

endmodule

[rtl/core/ycfu_scale_lane.sv]
// stages two to five of one component: magnitude, split multiply, rounding,
// signed add with clamp; depends on ycfu_pkg
module ycfu_scale_lane #(
    parameter int FIELD_BITS = ycfu_pkg::FIELD_BITS_DEFAULT
) (
    input  logic                              clk,
    input  ycfu_pkg::ycfu_pipe_ctrl_t         ctrl,
    input  logic [ycfu_pkg::COEF_BITS-1:0]    coef,
    input  logic signed [FIELD_BITS+1:0]      diff,
    input  logic signed [FIELD_BITS-1:0]      target,
    input  logic                              hold,
    output logic signed [FIELD_BITS-1:0]      value,
    output logic                              sat
);

    localparam int CB     = ycfu_pkg::COEF_BITS;
    localparam int CF     = ycfu_pkg::COEF_FRAC;
    localparam int DIFF_W = FIELD_BITS + 2;
    localparam int MAG_W  = FIELD_BITS + 1;
    localparam int LO_W   = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PL_W   = LO_W + CB;
    localparam int PH_W   = HI_W + CB;
    localparam int PROD_W = MAG_W + CB + 1;
    localparam int Q_W    = FIELD_BITS + 3;
    localparam int R_W    = FIELD_BITS + 5;
    localparam logic signed [R_W-1:0] MAX_V = {{(R_W-FIELD_BITS+1){1'b0}}, {(FIELD_BITS-1){1'b1}}};
    localparam logic signed [R_W-1:0] MIN_V = {{(R_W-FIELD_BITS+1){1'b1}}, {(FIELD_BITS-1){1'b0}}};

    // stage 2
    logic [DIFF_W-1:0]            abs_full;
    logic [MAG_W-1:0]             mag_next;
    logic [MAG_W-1:0]             mag_reg;
    logic                         neg2_reg;
    logic signed [FIELD_BITS-1:0] tgt2_reg;
    logic                         hold2_reg;
    // stage 3
    logic [PL_W-1:0]              pl_next;
    logic [PH_W-1:0]              ph_next;
    logic [PL_W-1:0]              pl_reg;
    logic [PH_W-1:0]              ph_reg;
    logic                         neg3_reg;
    logic signed [FIELD_BITS-1:0] tgt3_reg;
    logic                         hold3_reg;
    // stage 4
    logic [PROD_W-1:0]            prod;
    logic [Q_W-1:0]               q_next;
    logic [Q_W-1:0]               q_reg;
    logic                         neg4_reg;
    logic signed [FIELD_BITS-1:0] tgt4_reg;
    logic                         hold4_reg;
    // stage 5
    logic signed [R_W-1:0]        t_ext;
    logic signed [R_W-1:0]        q_ext;
    logic signed [R_W-1:0]        sum;
    logic signed [FIELD_BITS-1:0] value_next;
    logic                         sat_next;
    logic signed [FIELD_BITS-1:0] value_reg;
    logic                         sat_reg;

    always_comb
    begin
        abs_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag_next = abs_full[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            mag_reg   <= mag_next;
            neg2_reg  <= diff[DIFF_W-1];
            tgt2_reg  <= target;
            hold2_reg <= hold;
        end
    end

    // magnitude split in two halves, one partial product each
    always_comb
    begin
        pl_next = PL_W'(mag_reg[LO_W-1:0]) * PL_W'(coef);
        ph_next = PH_W'(mag_reg[MAG_W-1:LO_W]) * PH_W'(coef);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            neg3_reg  <= neg2_reg;
            tgt3_reg  <= tgt2_reg;
            hold3_reg <= hold2_reg;
        end
    end

    // round to nearest, ties away from zero on the magnitude
    always_comb
    begin
        prod   = (PROD_W'(ph_reg) << LO_W) + PROD_W'(pl_reg) + PROD_W'(ycfu_pkg::ROUND_HALF);
        q_next = prod[CF +: Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            q_reg     <= q_next;
            neg4_reg  <= neg3_reg;
            tgt4_reg  <= tgt3_reg;
            hold4_reg <= hold3_reg;
        end
    end

    always_comb
    begin
        t_ext = R_W'(tgt4_reg);
        q_ext = $signed({{(R_W-Q_W){1'b0}}, q_reg});
        sum   = neg4_reg ? t_ext - q_ext : t_ext + q_ext;
        if (hold4_reg)
        begin
            value_next = tgt4_reg;
            sat_next   = 1'b0;
        end
        else if (sum > MAX_V)
        begin
            value_next = MAX_V[FIELD_BITS-1:0];
            sat_next   = 1'b1;
        end
        else if (sum < MIN_V)
        begin
            value_next = MIN_V[FIELD_BITS-1:0];
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = sum[FIELD_BITS-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign value = value_reg;
    assign sat   = sat_reg;

endmodule

[rtl/core/yee_curl_field_update_top.sv]
// Yee curl field update, one grid cell per beat. Each item beat carries a cell's
// three target components, its three source components and six neighbor
// values; each target gets C times the curl difference added, rounded to
// nearest and clamped to the signed field range, with a saturation flag; x passes
// through unchanged with fewer than two dimensions. The pipeline takes one beat
// per cycle while the item side is not held off: one stage forms the differences,
// then magnitude, split multiply, rounding and the clamped add each take a
// register stage. A stall on the result side holds the filled stages in place
// while empty stages behind them keep filling; the item side is held off only
// once all five stages are full. Write step_coefficient (index 0, unsigned Q2.16)
// and grid_dimensions (index 1) only while no beat is in flight.
module yee_curl_field_update_top #(
    parameter int FIELD_BITS = ycfu_pkg::FIELD_BITS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    ycfu_item_if.sink                                item,
    ycfu_result_if.source                            result,
    input  logic                                     write_enable,
    input  logic [ycfu_pkg::CFG_INDEX_BITS-1:0]      register_index,
    input  logic [ycfu_pkg::CFG_DATA_BITS-1:0]       write_data
);

    logic [ycfu_pkg::COEF_BITS-1:0] coef_reg;
    logic [ycfu_pkg::DIM_BITS-1:0]  dims_reg;
    ycfu_pkg::ycfu_pipe_ctrl_t      ctrl;

    logic signed [FIELD_BITS+1:0] diff_x;
    logic signed [FIELD_BITS+1:0] diff_y;
    logic signed [FIELD_BITS+1:0] diff_z;
    logic signed [FIELD_BITS-1:0] tgt_x;
    logic signed [FIELD_BITS-1:0] tgt_y;
    logic signed [FIELD_BITS-1:0] tgt_z;
    logic                         hold_x;
    logic signed [FIELD_BITS-1:0] value_x;
    logic signed [FIELD_BITS-1:0] value_y;
    logic signed [FIELD_BITS-1:0] value_z;
    logic                         sat_x;
    logic                         sat_y;
    logic                         sat_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= ycfu_pkg::COEF_RESET;
            dims_reg <= ycfu_pkg::DIM_RESET;
        end
        else if (write_enable)
        begin
            case (register_index)
                ycfu_pkg::REG_STEP_COEFFICIENT:
                begin
                    coef_reg <= write_data[ycfu_pkg::COEF_BITS-1:0];
                end
                ycfu_pkg::REG_GRID_DIMENSIONS:
                begin
                    dims_reg <= write_data[ycfu_pkg::DIM_BITS-1:0];
                end
                default:
                begin
                    coef_reg <= coef_reg;
                end
            endcase
        end
    end

    ycfu_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .ctrl      (ctrl)
    );

    ycfu_curl_diff #(.FIELD_BITS(FIELD_BITS)) u_diff (
        .clk             (clk),
        .en              (ctrl.en[0]),
        .dims            (dims_reg),
        .target_x        (item.target_x),
        .target_y        (item.target_y),
        .target_z        (item.target_z),
        .source_x        (item.source_x),
        .source_y        (item.source_y),
        .source_z        (item.source_z),
        .source_x_near_j (item.source_x_near_j),
        .source_x_near_k (item.source_x_near_k),
        .source_y_near_i (item.source_y_near_i),
        .source_y_near_k (item.source_y_near_k),
        .source_z_near_i (item.source_z_near_i),
        .source_z_near_j (item.source_z_near_j),
        .diff_x          (diff_x),
        .diff_y          (diff_y),
        .diff_z          (diff_z),
        .tgt_x           (tgt_x),
        .tgt_y           (tgt_y),
        .tgt_z           (tgt_z),
        .hold_x          (hold_x)
    );

    // x passes through unchanged in one dimension
    ycfu_scale_lane #(.FIELD_BITS(FIELD_BITS)) u_lane_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef   (coef_reg),
        .diff   (diff_x),
        .target (tgt_x),
        .hold   (hold_x),
        .value  (value_x),
        .sat    (sat_x)
    );

    ycfu_scale_lane #(.FIELD_BITS(FIELD_BITS)) u_lane_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef   (coef_reg),
        .diff   (diff_y),
        .target (tgt_y),
        .hold   (1'b0),
        .value  (value_y),
        .sat    (sat_y)
    );

    ycfu_scale_lane #(.FIELD_BITS(FIELD_BITS)) u_lane_z (
        .clk    (clk),
        .ctrl   (ctrl),
        .coef   (coef_reg),
        .diff   (diff_z),
        .target (tgt_z),
        .hold   (1'b0),
        .value  (value_z),
        .sat    (sat_z)
    );

    assign result.updated_x = value_x;
    assign result.updated_y = value_y;
    assign result.updated_z = value_z;
    assign result.saturated = sat_x | sat_y | sat_z;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for yee_curl_field_update_top: a table of directed cells, then random
// phases under several coefficient and dimension settings, every beat checked against a table value or a predictor
// depends on ycfu_pkg, the ycfu_if stream interfaces and the rtl top

module testbench;
    import ycfu_pkg::*;

    localparam int FW = FIELD_BITS_DEFAULT;
    localparam logic [FW-1:0] F_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic [FW-1:0] F_MIN = {1'b1, {(FW-1){1'b0}}};

    typedef struct packed {
        logic [FW-1:0] target_x;
        logic [FW-1:0] target_y;
        logic [FW-1:0] target_z;
        logic [FW-1:0] source_x;
        logic [FW-1:0] source_y;
        logic [FW-1:0] source_z;
        logic [FW-1:0] source_x_near_j;
        logic [FW-1:0] source_x_near_k;
        logic [FW-1:0] source_y_near_i;
        logic [FW-1:0] source_y_near_k;
        logic [FW-1:0] source_z_near_i;
        logic [FW-1:0] source_z_near_j;
    } cell_t;

    typedef struct packed {
        logic [FW-1:0] updated_x;
        logic [FW-1:0] updated_y;
        logic [FW-1:0] updated_z;
        logic          saturated;
    } update_t;

    typedef struct {
        logic [COEF_BITS-1:0] coef;
        logic [DIM_BITS-1:0]  dims;
        cell_t                grid_cell;
        bit                   known;
        update_t              want;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      write_enable;
    logic [CFG_INDEX_BITS-1:0] register_index;
    logic [CFG_DATA_BITS-1:0]  write_data;

    ycfu_item_if   #(.FIELD_BITS(FW)) item_bus ();
    ycfu_result_if #(.FIELD_BITS(FW)) result_bus ();

    yee_curl_field_update_top #(.FIELD_BITS(FW)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_bus),
        .result         (result_bus),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data)
    );

    logic [COEF_BITS-1:0] coef_now = COEF_RESET;
    logic [DIM_BITS-1:0]  dims_now = DIM_RESET;
    update_t              pending_updates [$];
    int                   errors = 0;
    int                   cells_sent = 0;
    int                   updates_seen = 0;
    int                   clipped_seen = 0;
    int                   settings_used = 1;
    bit                   calm = 1'b0;

    row_t plan [21] = '{
        '{COEF_RESET, DIM_THREE, '0, 1'b1, '0},
        '{COEF_RESET, DIM_THREE, '{F_MAX, F_MAX, F_MAX, 0, 0, 0,
            F_MAX, F_MIN, F_MIN, F_MAX, F_MAX, F_MIN}, 1'b1, '{F_MAX, F_MAX, F_MAX, 1'b1}},
        '{COEF_RESET, DIM_THREE, '{F_MIN, F_MIN, F_MIN, 0, 0, 0,
            F_MAX, F_MIN, F_MIN, F_MAX, F_MAX, F_MIN}, 1'b1, '{F_MAX, F_MAX, F_MAX, 1'b0}},
        '{COEF_RESET, DIM_THREE, '{F_MAX, F_MAX, F_MAX, 0, 0, 0,
            F_MIN, F_MAX, F_MAX, F_MIN, F_MIN, F_MAX}, 1'b1, '{F_MIN, F_MIN, F_MIN, 1'b0}},
        '{COEF_RESET, DIM_THREE, '{F_MIN, F_MIN, F_MIN, 0, 0, 0,
            F_MIN, F_MAX, F_MAX, F_MIN, F_MIN, F_MAX}, 1'b1, '{F_MIN, F_MIN, F_MIN, 1'b1}},
        '{COEF_RESET, DIM_THREE, '{default: F_MAX}, 1'b1, '{F_MAX, F_MAX, F_MAX, 1'b0}},
        '{COEF_RESET, DIM_THREE, '{default: F_MIN}, 1'b1, '{F_MIN, F_MIN, F_MIN, 1'b0}},
        '{COEF_RESET, DIM_THREE, '{default: 32'hFFFF_FFFF}, 1'b1,
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
        '{COEF_RESET, DIM_THREE, '{32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h0003_8000,
            32'hFFFC_4000, 32'h0000_0001, 32'h0002_0000, 32'hFFFF_FFFF, 32'h4000_0000,
            32'hC000_0000, 32'h0000_8000, 32'h7FFF_0000}, 1'b0, '0},
        // half-unit products round away from zero
        '{18'd32768, DIM_THREE, '{0, 0, 0, 0, 0, 0, 0, 1, 3, 1, 0, 0}, 1'b1,
            '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0}},
        '{18'd32768, DIM_THREE, '{32'h0000_0003, 32'hFFFF_FFFD, 0, 32'h0000_0001,
            32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0004, 32'hFFFF_FFFE,
            32'h0000_0005, 32'h0000_0007, 32'hFFFF_FFF9}, 1'b0, '0},
        '{18'd0, DIM_THREE, '{32'h0ABC_DEF0, 32'hF000_0001, 32'h7FFF_0000, 0, 0, 0,
            F_MAX, F_MIN, F_MIN, F_MAX, F_MAX, F_MIN}, 1'b1,
            '{32'h0ABC_DEF0, 32'hF000_0001, 32'h7FFF_0000, 1'b0}},
        '{18'h3FFFF, DIM_THREE, '{0, 0, 0, 0, 0, 0,
            F_MAX, F_MIN, F_MIN, F_MAX, F_MAX, F_MIN}, 1'b0, '0},
        '{18'h3FFFF, DIM_THREE, '{32'h0010_0000, 32'hFFF0_0000, 32'h0000_0100, 32'h0000_0011,
            32'hFFFF_FFEE, 32'h0000_0300, 32'h0001_0001, 32'hFFFE_FFFF, 32'h0000_0003,
            32'h0000_0005, 32'hFFFF_FF00, 32'h0000_00FF}, 1'b0, '0},
        // one axis: x passes through and never clips
        '{COEF_RESET, 2'd1, '{F_MAX, 0, 0, 0, 0, 0, 0, 0, 0, F_MAX, 0, F_MIN}, 1'b1,
            '{F_MAX, 0, 0, 1'b0}},
        '{COEF_RESET, 2'd1, '{32'h4000_0000, 32'h7FFF_F000, 32'h8000_1000, 32'h1111_1111,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h2222_2222, 32'h3333_3333, 32'hC000_0000,
            32'h5555_5555, 32'h8000_0000, 32'hAAAA_AAAA}, 1'b0, '0},
        // zero dimensions behaves as one
        '{COEF_RESET, 2'd0, '{F_MAX, 0, 0, 0, 0, 0, 0, 0, 0, F_MAX, 0, F_MIN}, 1'b1,
            '{F_MAX, 0, 0, 1'b0}},
        '{COEF_RESET, 2'd0, '{32'h4000_0000, 32'h7FFF_F000, 32'h8000_1000, 32'h1111_1111,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h2222_2222, 32'h3333_3333, 32'hC000_0000,
            32'h5555_5555, 32'h8000_0000, 32'hAAAA_AAAA}, 1'b0, '0},
        '{COEF_RESET, DIM_TWO, '{0, 0, 0, 0, 0, 0,
            F_MAX, F_MIN, F_MIN, F_MAX, F_MAX, F_MIN}, 1'b0, '0},
        '{COEF_RESET, DIM_TWO, '{32'h0010_0000, 32'hFFF0_0000, 32'h0000_0100, 32'h0000_0011,
            32'hFFFF_FFEE, 32'h0000_0300, 32'h0001_0001, 32'hFFFE_FFFF, 32'h0000_0003,
            32'h0000_0005, 32'hFFFF_FF00, 32'h0000_00FF}, 1'b0, '0},
        '{COEF_RESET, DIM_THREE, '{32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h0003_8000,
            32'hFFFC_4000, 32'h0000_0001, 32'h0002_0000, 32'hFFFF_FFFF, 32'h4000_0000,
            32'hC000_0000, 32'h0000_8000, 32'h7FFF_0000}, 1'b0, '0}
    };

    function automatic longint wide(input logic [FW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [FW-1:0] add_scaled_curl(input logic [FW-1:0] target,
                                                      input longint delta, inout bit clipped);
        longint mag;
        longint step;
        longint total;
        mag = (delta < 0) ? -delta : delta;
        step = (mag * longint'(coef_now) + ROUND_HALF) >> COEF_FRAC;
        if (delta < 0)
        begin
            step = -step;
        end
        total = wide(target) + step;
        if (total > wide(F_MAX))
        begin
            total = wide(F_MAX);
            clipped = 1'b1;
        end
        else if (total < wide(F_MIN))
        begin
            total = wide(F_MIN);
            clipped = 1'b1;
        end
        return total[FW-1:0];
    endfunction

    function automatic update_t curl_update(input cell_t c);
        longint  dx;
        longint  dy;
        longint  dz;
        bit      clipped;
        update_t r;
        dx = 0;
        dy = 0;
        dz = 0;
        clipped = 1'b0;
        if (dims_now == DIM_THREE)
        begin
            dx += wide(c.source_y_near_k) - wide(c.source_y);
            dy += wide(c.source_x) - wide(c.source_x_near_k);
        end
        if (dims_now >= DIM_TWO)
        begin
            dx += wide(c.source_z) - wide(c.source_z_near_j);
            dz += wide(c.source_x_near_j) - wide(c.source_x);
        end
        dy += wide(c.source_z_near_i) - wide(c.source_z);
        dz += wide(c.source_y) - wide(c.source_y_near_i);
        if (dims_now >= DIM_TWO)
        begin
            r.updated_x = add_scaled_curl(c.target_x, dx, clipped);
        end
        else
        begin
            r.updated_x = c.target_x;
        end
        r.updated_y = add_scaled_curl(c.target_y, dy, clipped);
        r.updated_z = add_scaled_curl(c.target_z, dz, clipped);
        r.saturated = clipped;
        return r;
    endfunction

    function automatic logic [FW-1:0] any_field();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 512) - 32'd256;
            2: return $urandom_range(0, 1) ? F_MAX - $urandom_range(0, 64)
                                           : F_MIN + $urandom_range(0, 64);
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic cell_t any_cell();
        cell_t c;
        for (int n = 0; n < 12; n++)
        begin
            c[n*FW +: FW] = any_field();
        end
        return c;
    endfunction

    task automatic present(input cell_t c);
        item_bus.target_x        <= c.target_x;
        item_bus.target_y        <= c.target_y;
        item_bus.target_z        <= c.target_z;
        item_bus.source_x        <= c.source_x;
        item_bus.source_y        <= c.source_y;
        item_bus.source_z        <= c.source_z;
        item_bus.source_x_near_j <= c.source_x_near_j;
        item_bus.source_x_near_k <= c.source_x_near_k;
        item_bus.source_y_near_i <= c.source_y_near_i;
        item_bus.source_y_near_k <= c.source_y_near_k;
        item_bus.source_z_near_i <= c.source_z_near_i;
        item_bus.source_z_near_j <= c.source_z_near_j;
    endtask

    task automatic push_cell(input cell_t c, input bit known, input update_t want);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        present(c);
        do
        begin
            @(posedge clk);
        end
        while (!item_bus.ready);
        pending_updates.push_back(known ? want : curl_update(c));
        cells_sent++;
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (pending_updates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    task automatic program_registers(input logic [COEF_BITS-1:0] coef,
                                     input logic [DIM_BITS-1:0] dims);
        write_enable   <= 1'b1;
        register_index <= REG_STEP_COEFFICIENT;
        write_data     <= CFG_DATA_BITS'(coef);
        @(posedge clk);
        register_index <= REG_GRID_DIMENSIONS;
        write_data     <= CFG_DATA_BITS'(dims);
        @(posedge clk);
        write_enable <= 1'b0;
        coef_now = coef;
        dims_now = dims;
        settings_used++;
    endtask

    task automatic compare(input string name, input logic [FW-1:0] want,
                           input logic [FW-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        result_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            updates_seen++;
            if (pending_updates.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected update beat, expected none, actual %h %h %h %b",
                         $time, result_bus.updated_x, result_bus.updated_y,
                         result_bus.updated_z, result_bus.saturated);
            end
            else
            begin
                want = pending_updates.pop_front();
                if (want.saturated)
                begin
                    clipped_seen++;
                end
                compare("updated_x", want.updated_x, result_bus.updated_x);
                compare("updated_y", want.updated_y, result_bus.updated_y);
                compare("updated_z", want.updated_z, result_bus.updated_z);
                compare("saturated", FW'(want.saturated), FW'(result_bus.saturated));
            end
        end
    end

    initial
    begin
        logic [COEF_BITS-1:0] coef;
        logic [DIM_BITS-1:0]  dims;
        rst_n          <= 1'b0;
        write_enable   <= 1'b0;
        register_index <= REG_STEP_COEFFICIENT;
        write_data     <= '0;
        item_bus.valid <= 1'b0;
        present('0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].coef != coef_now || plan[n].dims != dims_now)
            begin
                settle();
                program_registers(plan[n].coef, plan[n].dims);
            end
            push_cell(plan[n].grid_cell, plan[n].known, plan[n].want);
        end

        // last phase runs with no idling on either side
        for (int p = 0; p < 8; p++)
        begin
            settle();
            calm = (p == 7);
            case (p)
                0: coef = 18'h3FFFF;
                1: coef = '0;
                2: coef = 18'd32768;
                7: coef = COEF_RESET;
                default: coef = $urandom_range(0, 18'h3FFFF);
            endcase
            dims = (p == 7) ? DIM_THREE : DIM_BITS'(p % 4);
            program_registers(coef, dims);
            repeat (160) push_cell(any_cell(), 1'b0, '0);
        end

        settle();
        repeat (4 * NUM_STAGES) @(posedge clk);
        $display("sent %0d cells over %0d register settings, %0d update beats checked",
                 cells_sent, settings_used, updates_seen);
        $display("%0d of the expected updates were clipped to the field range", clipped_seen);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ycfu_pkg.sv
rtl/core/ycfu_if.sv
rtl/core/ycfu_pipe_ctrl.sv
rtl/core/ycfu_curl_diff.sv
rtl/core/ycfu_scale_lane.sv
rtl/core/yee_curl_field_update_top.sv
dv/testbench.sv
